// ----- hdl/mmd_pkg.sv -----
package mmd_pkg;

   // Number of coordinates per point and the resulting count of sign patterns.
   localparam int DIMS = 5;
   localparam int PATTERNS = 1 << DIMS;

   // Default coordinate width and the fixed width of the distance result.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int OUT_W = 27;

   // Depth of the result queue; it covers the pipeline latency at full rate.
   localparam int QUEUE_DEPTH = 16;

   // Control that travels alongside a point through the first pipeline stage.
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage

// ----- hdl/mmd_lane.sv -----
module mmd_lane import mmd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int PATTERN = 0,
   localparam int SUM_W = COORD_WIDTH + $clog2(DIMS) + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [DIMS-1:0][COORD_WIDTH-1:0] coord,
   input  stage_ctl_type                    s1_ctl,
   output logic [SUM_W-1:0]                 diff_ff
);

   // Tracker reset values: above and below every possible running sum.
   localparam logic signed [SUM_W-1:0] TRK_TOP =
      SUM_W'((64'd1 << (COORD_WIDTH + 2)) - 64'd1);
   localparam logic signed [SUM_W-1:0] TRK_BOT = ~TRK_TOP;

   logic signed [SUM_W-1:0] sum_in, sum_ff;
   logic signed [SUM_W-1:0] min_ff, max_ff, min_in, max_in;
   logic signed [SUM_W-1:0] new_min, new_max;
   logic signed [SUM_W-1:0] snap_min_ff, snap_max_ff;

   // Signed sum of the coordinates for this lane's sign pattern.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < DIMS; k++) begin
         if (((PATTERN >> k) & 1) != 0) begin
            sum_in = sum_in + {{(SUM_W-COORD_WIDTH){coord[k][COORD_WIDTH-1]}}, coord[k]};
         end else begin
            sum_in = sum_in - {{(SUM_W-COORD_WIDTH){coord[k][COORD_WIDTH-1]}}, coord[k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Fold the registered sum into the extremes; a last point resets them.
   always_comb begin
      new_min = (sum_ff < min_ff) ? sum_ff : min_ff;
      new_max = (sum_ff > max_ff) ? sum_ff : max_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (s1_ctl.valid) begin
         if (s1_ctl.last) begin
            min_in = TRK_TOP;
            max_in = TRK_BOT;
         end else begin
            min_in = new_min;
            max_in = new_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= TRK_TOP;
         max_ff <= TRK_BOT;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // Capture the final extremes of a set when its last point is folded in.
   always_ff @(posedge clock) begin
      if (s1_ctl.valid && s1_ctl.last) begin
         snap_min_ff <= new_min;
         snap_max_ff <= new_max;
      end
   end

   // Spread of this pattern; it is never negative once a last point is folded in,
   // and it always fits the sum width.
   always_ff @(posedge clock) begin
      diff_ff <= snap_max_ff - snap_min_ff;
   end

endmodule

// ----- hdl/mmd_merge.sv -----
module mmd_merge import mmd_pkg::*; #(
   parameter int W = 28
) (
   input  logic                       clock,
   input  logic [PATTERNS-1:0][W-1:0] leaf,
   output logic [W-1:0]               root
);

   // Heap-ordered maximum tree: node i has children 2i+1 and 2i+2, and the
   // indexes from PATTERNS-1 upward are the lane spreads. Every node is a
   // register, so the root trails the leaves by one register per tree level.
   logic [W-1:0] node_ff [PATTERNS-1];
   logic [W-1:0] node_in [PATTERNS-1];

   for (genvar i = 0; i < PATTERNS - 1; i++) begin : g_node
      logic [W-1:0] lhs, rhs;

      if (2 * i + 1 >= PATTERNS - 1) begin : g_leaf
         assign lhs = leaf[2 * i + 1 - (PATTERNS - 1)];
         assign rhs = leaf[2 * i + 2 - (PATTERNS - 1)];
      end else begin : g_inner
         assign lhs = node_ff[2 * i + 1];
         assign rhs = node_ff[2 * i + 2];
      end

      assign node_in[i] = (lhs > rhs) ? lhs : rhs;

      always_ff @(posedge clock) begin
         node_ff[i] <= node_in[i];
      end
   end

   assign root = node_ff[0];

endmodule

// ----- hdl/max_manhattan_distance_5d.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_coord_0..4, req_last_point
// rsp_      out        rsp_valid/rsp_ready  rsp_max_distance
//
// One point is accepted per cycle while req_ready is high; all 32 sign patterns
// have a lane of their own. A result appears on rsp_valid once its last point
// has passed the registers for the pattern sums, the tracker update and the
// spread, five levels of registered maximum tree over the lanes, and the queue.
// Results wait in a 16-entry queue; req_ready drops only when 16 results are
// queued or still in the pipeline. Reset is synchronous and clears the trackers.
module max_manhattan_distance_5d import mmd_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_WIDTH-1:0] req_coord_0,
   input  logic [COORD_WIDTH-1:0] req_coord_1,
   input  logic [COORD_WIDTH-1:0] req_coord_2,
   input  logic [COORD_WIDTH-1:0] req_coord_3,
   input  logic [COORD_WIDTH-1:0] req_coord_4,
   input  logic                   req_last_point,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_max_distance
);

   localparam int SUM_W = COORD_WIDTH + $clog2(DIMS) + 1;
   localparam int QB = $clog2(QUEUE_DEPTH);

   logic                             accept, push, pop;
   logic [DIMS-1:0][COORD_WIDTH-1:0] coord;
   stage_ctl_type                    s1_ff, s1_in;
   logic [DIMS+1:0]                  res_pipe_ff, res_pipe_in;
   logic [PATTERNS-1:0][SUM_W-1:0]   spread;
   logic [SUM_W-1:0]                 root;
   logic [OUT_W-1:0]                 sat;

   logic [OUT_W-1:0] q_ff [QUEUE_DEPTH];
   logic [QB-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QB:0]      cnt_ff, cnt_in, occ_ff, occ_in;

   assign coord[0] = req_coord_0;
   assign coord[1] = req_coord_1;
   assign coord[2] = req_coord_2;
   assign coord[3] = req_coord_3;
   assign coord[4] = req_coord_4;

   assign accept = req_valid && req_ready;

   // Control for the sum stage, and the marker of a finished set walking
   // through the snapshot, spread and tree stages.
   assign s1_in.valid = accept;
   assign s1_in.last  = req_last_point;
   assign res_pipe_in = {res_pipe_ff[DIMS:0], s1_ff.valid & s1_ff.last};
   assign push        = res_pipe_ff[DIMS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         res_pipe_ff <= '0;
      end else begin
         s1_ff       <= s1_in;
         res_pipe_ff <= res_pipe_in;
      end
   end

   // One lane for every sign pattern.
   for (genvar p = 0; p < PATTERNS; p++) begin : g_lane
      mmd_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .PATTERN     (p)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .coord   (coord),
         .s1_ctl  (s1_ff),
         .diff_ff (spread[p])
      );
   end

   mmd_merge #(
      .W (SUM_W)
   ) u_merge (
      .clock (clock),
      .leaf  (spread),
      .root  (root)
   );

   // Clamp the largest spread to the result width.
   if (SUM_W > OUT_W) begin : g_sat
      assign sat = (|root[SUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : root[OUT_W-1:0];
   end else begin : g_nosat
      assign sat = OUT_W'(root);
   end

   // Result queue; occupancy counts results both queued and still in flight.
   assign rsp_valid        = (cnt_ff != '0);
   assign rsp_max_distance = q_ff[rd_ptr_ff];
   assign pop              = rsp_valid && rsp_ready;
   assign req_ready        = (occ_ff < (QB+1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QB+1)'(push) - (QB+1)'(pop);
      occ_in    = occ_ff + (QB+1)'(accept && req_last_point) - (QB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= sat;
      end
   end

endmodule

// ----- tb/max_manhattan_distance_5d_tb.sv -----
module max_manhattan_distance_5d_tb import mmd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W = COORD_WIDTH_DEF;
   localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam int SUM_TOP = (1 << (COORD_W + 2)) - 1;
   localparam int DIST_MAX = (1 << OUT_W) - 1;
   localparam int RANDOM_POINTS = 1430;
   localparam int TAIL_POINTS = 150;
   localparam int LONG_HOLD_AT = 600;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic [DIMS-1:0][COORD_W-1:0] coord;
      logic last;
      logic wait_drain;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [COORD_W-1:0] req_coord_0 = '0;
   logic [COORD_W-1:0] req_coord_1 = '0;
   logic [COORD_W-1:0] req_coord_2 = '0;
   logic [COORD_W-1:0] req_coord_3 = '0;
   logic [COORD_W-1:0] req_coord_4 = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_max_distance;

   // Stimulus and expected distances.
   point_type point_q[$];
   logic [OUT_W-1:0] dist_expected_q[$];

   // Predictor state: running minimum and maximum of each sign-pattern sum.
   int low_sum[PATTERNS];
   int high_sum[PATTERNS];

   // Status shared between processes, updated nonblocking but for the queue counts.
   int points_queued = 0;
   int sets_queued = 0;
   int points_accepted = 0;
   int results_pending = 0;
   int distances_checked = 0;
   int mismatch_count = 0;
   int input_stall_cycles = 0;
   int send_gap = 0;
   int take_gap = 0;
   int hold_left = 0;
   int points_sent = 0;
   logic hold_done = 1'b0;
   logic quiet_tail = 1'b0;

   max_manhattan_distance_5d dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_coord_0      (req_coord_0),
      .req_coord_1      (req_coord_1),
      .req_coord_2      (req_coord_2),
      .req_coord_3      (req_coord_3),
      .req_coord_4      (req_coord_4),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_max_distance (rsp_max_distance)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Put every tracker back to its empty value.
   task automatic clear_trackers();
      for (int p = 0; p < PATTERNS; p++) begin
         low_sum[p] = SUM_TOP;
         high_sum[p] = -SUM_TOP - 1;
      end
   endtask

   // Fold one accepted point into the trackers; a last point yields a distance.
   task automatic fold_point(input logic [DIMS-1:0][COORD_W-1:0] pt, input logic last);
      int sum;
      int c;
      int spread;
      int best;
      for (int p = 0; p < PATTERNS; p++) begin
         sum = 0;
         for (int k = 0; k < DIMS; k++) begin
            c = $signed(pt[k]);
            if (p[k]) begin
               sum += c;
            end else begin
               sum -= c;
            end
         end
         if (sum < low_sum[p]) low_sum[p] = sum;
         if (sum > high_sum[p]) high_sum[p] = sum;
      end
      if (last) begin
         best = 0;
         for (int p = 0; p < PATTERNS; p++) begin
            spread = high_sum[p] - low_sum[p];
            if (spread > best) best = spread;
         end
         if (best > DIST_MAX) best = DIST_MAX;
         dist_expected_q.push_back(best[OUT_W-1:0]);
         clear_trackers();
      end
   endtask

   task automatic queue_point(input logic [DIMS-1:0][COORD_W-1:0] c, input logic last,
                              input logic wait_drain);
      point_type pt;
      pt.coord = c;
      pt.last = last;
      pt.wait_drain = wait_drain;
      point_q.push_back(pt);
      points_queued++;
      if (last) sets_queued++;
   endtask

   // Coordinate of a given flavor: full range, near zero, extremes, or a mix.
   function automatic logic [COORD_W-1:0] rand_coord(int style);
      logic [31:0] r;
      int pick;
      r = $urandom;
      pick = (style == 3) ? int'(r[31:30]) % 3 : style;
      case (pick)
         0: return r[COORD_W-1:0];
         1: return COORD_W'(int'($urandom_range(0, 400)) - 200);
         default: begin
            case (r[1:0])
               2'd0: return CMAX;
               2'd1: return CMIN;
               2'd2: return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   // Request driver: offers queued points, with random gaps and drain pauses.
   always @(posedge clock) begin : sender
      point_type nxt;
      quiet_tail <= (point_q.size() < TAIL_POINTS);
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (point_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (point_q[0].wait_drain && (req_valid || results_pending != 0)) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && ((points_sent / 160) % 3 != 2) &&
                      $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(0, 3);
         end else begin
            nxt = point_q.pop_front();
            req_valid <= 1'b1;
            req_coord_0 <= nxt.coord[0];
            req_coord_1 <= nxt.coord[1];
            req_coord_2 <= nxt.coord[2];
            req_coord_3 <= nxt.coord[3];
            req_coord_4 <= nxt.coord[4];
            req_last_point <= nxt.last;
            points_sent <= points_sent + 1;
         end
      end
   end

   // Result-side ready: short random stalls and one long hold to fill the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap <= 0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && points_accepted >= LONG_HOLD_AT) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD - 1;
         hold_done <= 1'b1;
      end else if (take_gap != 0) begin
         rsp_ready <= 1'b0;
         take_gap <= take_gap - 1;
      end else if (!quiet_tail && ((points_accepted / 130) % 3 != 1) &&
                   $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         take_gap <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predicts on every accepted request and checks every accepted result.
   always @(posedge clock) begin : monitor
      logic [OUT_W-1:0] want;
      if (reset) begin
         clear_trackers();
      end else begin
         if (req_valid && req_ready) begin
            fold_point({req_coord_4, req_coord_3, req_coord_2, req_coord_1, req_coord_0},
                       req_last_point);
            points_accepted <= points_accepted + 1;
         end
         if (req_valid && !req_ready) input_stall_cycles <= input_stall_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (dist_expected_q.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("%0t: unexpected result, max_distance %0d", $realtime,
                           rsp_max_distance);
            end else begin
               want = dist_expected_q.pop_front();
               distances_checked <= distances_checked + 1;
               if (rsp_max_distance !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("%0t: max_distance mismatch, expected %0d, got %0d",
                              $realtime, want, rsp_max_distance);
               end
            end
         end
         results_pending <= dist_expected_q.size();
      end
   end

   // Directed sets first, then random sets; then wait for the block to drain.
   initial begin : stimulus
      logic [DIMS-1:0][COORD_W-1:0] c;
      int set_len;
      int style;
      int set_no;
      int n;

      // A lone point always gives zero.
      queue_point('0, 1'b1, 1'b0);
      queue_point({DIMS{CMAX}}, 1'b1, 1'b0);
      // Opposite corners give the widest possible distance.
      queue_point({DIMS{CMAX}}, 1'b0, 1'b0);
      queue_point({DIMS{CMIN}}, 1'b1, 1'b0);
      // Alternating signs exercise the mixed sign patterns.
      queue_point({CMAX, CMIN, CMAX, CMIN, CMAX}, 1'b0, 1'b0);
      queue_point({CMIN, CMAX, CMIN, CMAX, CMIN}, 1'b1, 1'b0);
      // Repeated identical points also give zero.
      for (int i = 0; i < 3; i++) queue_point({DIMS{{COORD_W{1'b1}}}}, i == 2, 1'b0);
      // One axis at a time, closed by a point at the negative corner.
      for (int k = 0; k < DIMS; k++) begin
         c = '0;
         c[k] = CMAX;
         queue_point(c, 1'b0, 1'b0);
      end
      queue_point({DIMS{CMIN}}, 1'b1, 1'b0);
      // A short random set that starts only once the block has drained.
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < DIMS; k++) c[k] = rand_coord(0);
         queue_point(c, i == 3, i == 0);
      end

      // Random sets, mostly short so that results come often.
      n = 0;
      set_no = 0;
      while (n < RANDOM_POINTS) begin
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
         style = $urandom_range(0, 3);
         for (int i = 0; i < set_len; i++) begin
            for (int k = 0; k < DIMS; k++) c[k] = rand_coord(style);
            queue_point(c, i == set_len - 1, i == 0 && (set_no == 0 || set_no == 150));
         end
         n += set_len;
         set_no++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (points_accepted != points_queued || results_pending != 0);
      repeat (24) @(posedge clock);

      $display("Checked %0d distances over %0d points in %0d sets.", distances_checked,
               points_accepted, sets_queued);
      $display("The request side stalled for %0d cycles; %0d mismatches.",
               input_stall_cycles, mismatch_count);
      if (mismatch_count == 0 && dist_expected_q.size() == 0) begin
         $display("max_manhattan_distance_5d_tb OK");
      end else begin
         $display("max_manhattan_distance_5d_tb NOT OK");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Timed out with %0d distances still expected.", dist_expected_q.size());
      $display("max_manhattan_distance_5d_tb NOT OK");
      $finish;
   end

endmodule
